/* design/pocsag_pkg.sv */
package pocsag_pkg;

  localparam int WordBits = 32;
  localparam int DataBits = 31;
  localparam int SynBits  = 10;
  localparam int GenBits  = 11;
  localparam int AddrBits = 3;
  localparam int DataW    = 32;

  localparam logic [GenBits-1:0] GenReset = 11'h769;

  // register index as decoded from paddr[2]
  localparam logic RegGen = 1'b0;

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusBad = 1'b1;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [SynBits-1:0] syn_t;
  // syndrome contribution of each bit of the BCH word (codeword bits 31..1)
  typedef logic [DataBits-1:0][SynBits-1:0] col_tab_t;

endpackage

/* design/pocsag_cfg.sv */
module pocsag_cfg
  import pocsag_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready,
  output logic                busy,
  output col_tab_t            cols
);

  logic [GenBits-1:0]              gen;
  logic                            sweeping;
  logic [4:0]                      idx;
  logic [SynBits-1:0][SynBits-1:0] win;
  logic [DataBits-1:SynBits][SynBits-1:0] col_hi;
  syn_t                            new_col;
  logic                            wr_gen;

  assign pready = 1'b1;
  assign busy   = sweeping;
  assign wr_gen = psel & penable & pwrite & pready & (paddr[2] == RegGen);

  always_comb begin
    if (paddr[2] == RegGen) begin
      prdata = {{(DataW-GenBits){1'b0}}, gen};
    end else begin
      prdata = '0;
    end
  end

  // column j is the remainder of x^j: fed back from the previous ten columns
  always_comb begin
    new_col = '0;
    for (int k = 0; k < SynBits; k++) begin
      if (gen[k]) begin
        new_col = new_col ^ win[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen      <= GenReset;
      sweeping <= 1'b1;
      idx      <= 5'(SynBits);
      for (int k = 0; k < SynBits; k++) begin
        win[k] <= syn_t'(1) << k;
      end
    end else if (wr_gen) begin
      gen      <= pwdata[GenBits-1:0];
      sweeping <= 1'b1;
      idx      <= 5'(SynBits);
      for (int k = 0; k < SynBits; k++) begin
        win[k] <= syn_t'(1) << k;
      end
    end else if (sweeping) begin
      win <= {new_col, win[SynBits-1:1]};
      idx <= idx + 5'd1;
      if (idx == 5'(DataBits-1)) begin
        sweeping <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sweeping) begin
      col_hi[idx] <= new_col;
    end
  end

  always_comb begin
    for (int i = 0; i < SynBits; i++) begin
      cols[i] = syn_t'(1) << i;
    end
    for (int i = SynBits; i < DataBits; i++) begin
      cols[i] = col_hi[i];
    end
  end

endmodule

/* design/pocsag_dec.sv */
module pocsag_dec
  import pocsag_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  word_t    codeword_in,
  input  col_tab_t cols,
  output logic     done,
  output word_t    codeword_out,
  output logic     status
);

  logic                in_valid;
  word_t               in_word;
  syn_t                syn;
  logic [DataBits-1:0] match;
  logic [DataBits-1:0] pick;
  logic                par;
  word_t               res;
  logic                res_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_word <= codeword_in;
    end
  end

  always_comb begin
    syn = '0;
    for (int i = 0; i < DataBits; i++) begin
      if (in_word[i+1]) begin
        syn = syn ^ cols[i];
      end
    end
  end

  // flipping bit i+1 clears the syndrome when its column equals it
  always_comb begin
    for (int i = 0; i < DataBits; i++) begin
      match[i] = (cols[i] == syn);
    end
  end

  assign pick = match & (~match + {{(DataBits-1){1'b0}}, 1'b1});
  assign par  = ^in_word;

  always_comb begin
    res     = in_word;
    res_bad = StatusBad;
    if (syn == '0) begin
      res     = in_word ^ {{(WordBits-1){1'b0}}, par};
      res_bad = StatusOk;
    end else if (|match) begin
      // a single flip leaves overall parity even only if it was odd
      if (par) begin
        res     = in_word ^ {pick, 1'b0};
        res_bad = StatusOk;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      codeword_out <= res;
      status       <= res_bad;
    end
  end

endmodule

/* design/pocsag_bch_single_error_corrector.sv */
// POCSAG BCH(31,21) single-error corrector with even parity.
//
// Input: codeword_in is taken at a rising edge with start high and busy low.
// Output: done is high for one cycle with codeword_out and status; the
// receiver cannot stall, so results are never held back.
// The result passes the input register, then the result register. A new
// codeword may be accepted every cycle while busy is low; throughput is
// one codeword per clock.
// status low: word clean or corrected (parity bit or one bit of 31..1).
// status high: uncorrectable, codeword_out equals the input.
// Config: APB register 0 (address 0) holds the 11-bit generator polynomial.
// After reset, and after each write to it, busy is high while the
// per-bit syndrome table is rebuilt one column per cycle.
// Reset (rst, synchronous) restores generator 0x769 and drops any
// transaction in flight.
module pocsag_bch_single_error_corrector
  import pocsag_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  word_t               codeword_in,
  output logic                done,
  output word_t               codeword_out,
  output logic                status,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready
);

  col_tab_t cols;
  logic     accept;

  assign accept = start & ~busy;

  pocsag_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .busy    (busy),
    .cols    (cols)
  );

  pocsag_dec u_dec (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .codeword_in  (codeword_in),
    .cols         (cols),
    .done         (done),
    .codeword_out (codeword_out),
    .status       (status)
  );

endmodule

/* design/pocsag_chk.sv */
module pocsag_chk
  import pocsag_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input word_t               codeword_in,
  input logic                done,
  input word_t               codeword_out,
  input logic                status,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [AddrBits-1:0] paddr,
  input logic                pready
);

  a_lat: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("accepted transaction gave no result after two cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without an accepted transaction");

  a_ok_parity: assert property (@(posedge clk) disable iff (rst)
    done && status == StatusOk |-> (^codeword_out) == 1'b0)
    else $error("good status with odd parity");

  a_bad_unchanged: assert property (@(posedge clk) disable iff (rst)
    done && status == StatusBad |-> codeword_out == $past(codeword_in, 2))
    else $error("uncorrectable word was altered");

  a_rebuild: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[2] == RegGen |=> busy)
    else $error("generator write did not start table rebuild");

endmodule

bind pocsag_bch_single_error_corrector pocsag_chk u_chk (.*);
